FILE: src/tlaja_pkg.sv
`timescale 1ns / 1ps

package tlaja_pkg;

    localparam int unsigned LEN_W    = 15;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned ANGLE_W  = 16;
    localparam int unsigned ELBOW_W  = 14;

    localparam logic [LEN_W-1:0] LEN_RESET = 15'd6356;

    typedef enum logic {
        REG_FIRST_LINK  = 1'b0,
        REG_SECOND_LINK = 1'b1
    } t_reg_idx;

    // angles inside the datapath are in 2^-16 rad
    localparam int PI16      = 205887;
    localparam int HALF_PI16 = 102944;
    localparam int ELBOW_OUT_MAX = 12868;

    // square-root pipelines: radicand widths, one result bit per stage
    localparam int unsigned R_RAD_W = 56;
    localparam int unsigned S_RAD_W = 62;

    // CORDIC vectoring unit
    localparam int unsigned CIN_W        = 48;
    localparam int unsigned CX_W         = 51;
    localparam int unsigned ANG_W        = 19;
    localparam int unsigned NORM_BIT     = 40;
    localparam int unsigned CORDIC_STEPS = 17;
    localparam int unsigned ATAN_W       = 17;
    localparam int unsigned CORDIC_LAT   = 6 + CORDIC_STEPS + 1;

    localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047,
        17'd1024, 17'd512, 17'd256, 17'd128, 17'd64, 17'd32, 17'd16,
        17'd8, 17'd4, 17'd2, 17'd1
    };

    typedef struct packed {
        logic [CIN_W-1:0]       m;
        logic signed [CX_W-1:0] x;
        logic signed [CX_W-1:0] y;
    } t_norm;

endpackage

FILE: src/tlaja_isqrt.sv
`timescale 1ns / 1ps

module tlaja_isqrt #(
    parameter int unsigned RAD_W = 62
) (
    input  logic               i_clk,
    input  logic [RAD_W-1:0]   i_rad,
    output logic [RAD_W/2-1:0] o_root
);

    localparam int unsigned STEPS = RAD_W / 2;

    logic [RAD_W-1:0] r_v   [STEPS];
    logic [RAD_W-1:0] r_res [STEPS];
    logic [RAD_W-1:0] n_v   [STEPS];
    logic [RAD_W-1:0] n_res [STEPS];
    logic [RAD_W-1:0] s_v   [STEPS];
    logic [RAD_W-1:0] s_res [STEPS];

    // one root bit per stage, trial bit walks down two places each stage
    always_comb begin
        logic [RAD_W:0]   sum;
        logic [RAD_W-1:0] bitv;
        s_v[0]   = i_rad;
        s_res[0] = '0;
        for (int k = 1; k < STEPS; k++) begin
            s_v[k]   = r_v[k-1];
            s_res[k] = r_res[k-1];
        end
        for (int k = 0; k < STEPS; k++) begin
            bitv = '0;
            bitv[RAD_W-2-2*k] = 1'b1;
            sum = {1'b0, s_res[k]} + {1'b0, bitv};
            if ({1'b0, s_v[k]} >= sum) begin
                n_v[k]   = s_v[k] - sum[RAD_W-1:0];
                n_res[k] = (s_res[k] >> 1) + bitv;
            end else begin
                n_v[k]   = s_v[k];
                n_res[k] = s_res[k] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_res <= n_res;
    end

    assign o_root = r_res[STEPS-1][STEPS-1:0];

endmodule

FILE: src/tlaja_cordic.sv
`timescale 1ns / 1ps

module tlaja_cordic
    import tlaja_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [CIN_W-1:0] i_n,
    input  logic signed [CIN_W-1:0] i_d,
    output logic signed [ANG_W-1:0] o_ang
);

    logic                    r_sp0, r_ng0;
    logic signed [CIN_W-1:0] r_y0, r_x0, r_y1, r_x1;
    logic [CIN_W-1:0]        r_ay1;
    t_norm                   r_n2, r_n3, r_n4, r_n5;
    logic [CORDIC_LAT-3:0]   r_sp, r_ng;

    logic signed [CX_W-1:0]  r_x [CORDIC_STEPS];
    logic signed [CX_W-1:0]  r_y [CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_z [CORDIC_STEPS];
    logic signed [CX_W-1:0]  n_x [CORDIC_STEPS];
    logic signed [CX_W-1:0]  n_y [CORDIC_STEPS];
    logic signed [ANG_W-1:0] n_z [CORDIC_STEPS];
    logic signed [CX_W-1:0]  s_x [CORDIC_STEPS];
    logic signed [CX_W-1:0]  s_y [CORDIC_STEPS];
    logic signed [ANG_W-1:0] s_z [CORDIC_STEPS];
    logic signed [ANG_W-1:0] r_ang;

    // shift all three left by k unless that would carry the larger magnitude past the norm bit
    function automatic t_norm norm_by(t_norm a, int unsigned k);
        t_norm b;
        b = a;
        if (a.m < (CIN_W'(1) << (NORM_BIT + 1 - k))) begin
            b.m = a.m << k;
            b.x = a.x <<< k;
            b.y = a.y <<< k;
        end
        return b;
    endfunction

    // fold a negative denominator into the right half plane
    always_ff @(posedge i_clk) begin
        r_sp0 <= (i_d == '0);
        r_ng0 <= i_n[CIN_W-1];
        if (i_d[CIN_W-1]) begin
            r_y0 <= -i_n;
            r_x0 <= -i_d;
        end else begin
            r_y0 <= i_n;
            r_x0 <= i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ay1 <= r_y0[CIN_W-1] ? CIN_W'(-r_y0) : CIN_W'(r_y0);
        r_y1  <= r_y0;
        r_x1  <= r_x0;
        r_n2.m <= (r_ay1 > CIN_W'(r_x1)) ? r_ay1 : CIN_W'(r_x1);
        r_n2.x <= {{(CX_W-CIN_W){r_x1[CIN_W-1]}}, r_x1};
        r_n2.y <= {{(CX_W-CIN_W){r_y1[CIN_W-1]}}, r_y1};
        r_n3 <= norm_by(norm_by(r_n2, 32), 16);
        r_n4 <= norm_by(norm_by(r_n3, 8), 4);
        r_n5 <= norm_by(norm_by(r_n4, 2), 1);
        r_sp <= {r_sp[CORDIC_LAT-4:0], r_sp0};
        r_ng <= {r_ng[CORDIC_LAT-4:0], r_ng0};
    end

    always_comb begin
        s_x[0] = r_n5.x;
        s_y[0] = r_n5.y;
        s_z[0] = '0;
        for (int k = 1; k < CORDIC_STEPS; k++) begin
            s_x[k] = r_x[k-1];
            s_y[k] = r_y[k-1];
            s_z[k] = r_z[k-1];
        end
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            if (!s_y[k][CX_W-1]) begin
                n_x[k] = s_x[k] + (s_y[k] >>> k);
                n_y[k] = s_y[k] - (s_x[k] >>> k);
                n_z[k] = s_z[k] + $signed({2'b00, ATAN_TAB[k]});
            end else begin
                n_x[k] = s_x[k] - (s_y[k] >>> k);
                n_y[k] = s_y[k] + (s_x[k] >>> k);
                n_z[k] = s_z[k] - $signed({2'b00, ATAN_TAB[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
        if (r_sp[CORDIC_LAT-3]) begin
            r_ang <= r_ng[CORDIC_LAT-3] ? -$signed(ANG_W'(HALF_PI16))
                                        : $signed(ANG_W'(HALF_PI16));
        end else begin
            r_ang <= r_z[CORDIC_STEPS-1];
        end
    end

    assign o_ang = r_ang;

endmodule

FILE: src/two_link_arm_joint_angles.sv
`timescale 1ns / 1ps

// Inverse kinematics for a two-link arm: target (x, y, z) in, shoulder, elbow and
// wrist angles out. A target is taken on every cycle in which start is high (busy
// never rises), and its result is presented for exactly one cycle with o_valid;
// the receiver cannot stall, so results must be captured when o_valid is high.
// Latency is set by the 31-stage square root of the elbow term followed by the
// 24-stage CORDIC vectoring units. An unreachable target (or a zero link length)
// gives o_unreachable high and zero angles. Write the link lengths over the APB
// port only while no targets are in flight.
module two_link_arm_joint_angles
    import tlaja_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_target_x,
    input  logic signed [COORD_W-1:0] i_target_y,
    input  logic signed [COORD_W-1:0] i_target_z,
    output logic                      o_valid,
    output logic signed [ANGLE_W-1:0] o_shoulder_angle,
    output logic [ELBOW_W-1:0]        o_elbow_angle,
    output logic signed [ANGLE_W-1:0] o_wrist_angle,
    output logic                      o_unreachable,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int unsigned T_XZ   = 2;
    localparam int unsigned T_R    = T_XZ + R_RAD_W / 2;
    localparam int unsigned T_DIFF = 8;
    localparam int unsigned T_S    = T_DIFF + S_RAD_W / 2;
    localparam int unsigned T_CI   = T_S + 1;
    localparam int unsigned T_CO   = T_CI + CORDIC_LAT;
    localparam int unsigned T_OUT  = T_CO + 3;
    localparam int unsigned D_Y    = T_S - 1;
    localparam int unsigned D_AN   = T_S - 6;
    localparam int unsigned D_D2   = T_S - T_DIFF;
    localparam int unsigned D_R    = T_S - T_R;
    localparam int unsigned D_NG   = T_CO - 6;
    localparam int unsigned D_UN   = T_CO - 5;

    logic [LEN_W-1:0] r_l1, r_l2;
    logic [T_OUT-1:0] r_vld;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= LEN_RESET;
            r_l2 <= LEN_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_idx'(paddr[2]))
                REG_FIRST_LINK:  r_l1 <= pwdata[LEN_W-1:0];
                REG_SECOND_LINK: r_l2 <= pwdata[LEN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_FIRST_LINK:  prdata = 32'(r_l1);
            REG_SECOND_LINK: prdata = 32'(r_l2);
        endcase
    end

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[T_OUT-2:0], start};
        end
    end

    // stage 1: squares and link products
    logic signed [31:0] w_xx, w_yy, w_zz;
    logic [29:0]        w_l1l1, w_l2l2, w_l1l2;
    logic [30:0]        r_xx1, r_yy1, r_zz1;
    logic [29:0]        r_l1l1_1, r_l2l2_1, r_l1l2_1;
    logic signed [COORD_W-1:0] r_y1;

    assign w_xx   = i_target_x * i_target_x;
    assign w_yy   = i_target_y * i_target_y;
    assign w_zz   = i_target_z * i_target_z;
    assign w_l1l1 = r_l1 * r_l1;
    assign w_l2l2 = r_l2 * r_l2;
    assign w_l1l2 = r_l1 * r_l2;

    always_ff @(posedge i_clk) begin
        r_xx1    <= w_xx[30:0];
        r_yy1    <= w_yy[30:0];
        r_zz1    <= w_zz[30:0];
        r_l1l1_1 <= w_l1l1;
        r_l2l2_1 <= w_l2l2;
        r_l1l2_1 <= w_l1l2;
        r_y1     <= i_target_y;
    end

    // stage 2: sums
    logic [31:0] r_sxyz2, r_xz2;
    logic [30:0] r_ll2, r_den2;

    always_ff @(posedge i_clk) begin
        r_sxyz2 <= 32'(r_xx1) + 32'(r_yy1) + 32'(r_zz1);
        r_xz2   <= 32'(r_xx1) + 32'(r_zz1);
        r_ll2   <= 31'(r_l1l1_1) + 31'(r_l2l2_1);
        r_den2  <= {r_l1l2_1, 1'b0};
    end

    // stage 3: numerator of the cosine
    logic signed [32:0] r_num3;
    logic [30:0]        r_den3;

    always_ff @(posedge i_clk) begin
        r_num3 <= $signed({1'b0, r_sxyz2}) - $signed({2'b00, r_ll2});
        r_den3 <= r_den2;
    end

    // stages 4 and 5: reach check, normalize den into [2^30, 2^31)
    logic [32:0]        r_anum4;
    logic [30:0]        r_draw4, w_dn4, w_dn5;
    logic signed [32:0] w_nm4, w_nm5;
    logic [30:0]        r_den4, r_den5;
    logic signed [32:0] r_num4, r_num5;
    logic               r_un5;

    always_comb begin
        w_dn4 = r_den3;
        w_nm4 = r_num3;
        if (w_dn4[30:15] == '0) begin
            w_dn4 = w_dn4 << 16;
            w_nm4 = w_nm4 <<< 16;
        end
        if (w_dn4[30:23] == '0) begin
            w_dn4 = w_dn4 << 8;
            w_nm4 = w_nm4 <<< 8;
        end
        w_dn5 = r_den4;
        w_nm5 = r_num4;
        if (w_dn5[30:27] == '0) begin
            w_dn5 = w_dn5 << 4;
            w_nm5 = w_nm5 <<< 4;
        end
        if (w_dn5[30:29] == '0) begin
            w_dn5 = w_dn5 << 2;
            w_nm5 = w_nm5 <<< 2;
        end
        if (!w_dn5[30]) begin
            w_dn5 = w_dn5 << 1;
            w_nm5 = w_nm5 <<< 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_anum4 <= r_num3[32] ? 33'(-r_num3) : 33'(r_num3);
        r_draw4 <= r_den3;
        r_den4  <= w_dn4;
        r_num4  <= w_nm4;
        r_un5   <= (r_draw4 == '0) || (r_anum4 > {2'b00, r_draw4});
        r_den5  <= w_dn5;
        r_num5  <= w_nm5;
    end

    // stage 6: magnitude and sign of the normalized numerator
    logic [30:0]        r_anumn6, r_den6;
    logic signed [31:0] r_num6;
    logic               r_ng6;
    logic signed [32:0] w_abs5;

    assign w_abs5 = r_num5[32] ? -r_num5 : r_num5;

    always_ff @(posedge i_clk) begin
        r_anumn6 <= w_abs5[30:0];
        r_ng6    <= r_num5[32];
        r_num6   <= r_num5[31:0];
        r_den6   <= r_den5;
    end

    // stages 7 and 8: D^2 - N^2 and the second arctangent denominator
    logic [61:0]             w_den2, w_num2;
    logic [45:0]             w_l1den;
    logic signed [47:0]      w_l2num;
    logic [61:0]             r_den2_7, r_num2_7, r_diff8;
    logic [45:0]             r_l1den7;
    logic signed [47:0]      r_l2num7;
    logic signed [CIN_W-1:0] r_d2_8;

    assign w_den2  = r_den6 * r_den6;
    assign w_num2  = r_anumn6 * r_anumn6;
    assign w_l1den = r_l1 * r_den6;
    assign w_l2num = $signed({1'b0, r_l2}) * r_num6;

    always_ff @(posedge i_clk) begin
        r_den2_7 <= w_den2;
        r_num2_7 <= w_num2;
        r_l1den7 <= w_l1den;
        r_l2num7 <= w_l2num;
        r_diff8  <= r_den2_7 - r_num2_7;
        r_d2_8   <= $signed({2'b00, r_l1den7}) + r_l2num7;
    end

    // square roots
    logic [R_RAD_W/2-1:0] w_r;
    logic [S_RAD_W/2-1:0] w_s;

    tlaja_isqrt #(.RAD_W(R_RAD_W)) u_sqrt_r (
        .i_clk  (i_clk),
        .i_rad  ({r_xz2, 24'b0}),
        .o_root (w_r)
    );

    tlaja_isqrt #(.RAD_W(S_RAD_W)) u_sqrt_s (
        .i_clk  (i_clk),
        .i_rad  (r_diff8),
        .o_root (w_s)
    );

    // align side data with the square-root outputs
    logic signed [COORD_W-1:0] r_y_dly  [D_Y];
    logic [30:0]               r_an_dly [D_AN];
    logic signed [CIN_W-1:0]   r_d2_dly [D_D2];
    logic [R_RAD_W/2-1:0]      r_r_dly  [D_R];
    logic [D_NG-1:0]           r_ng_dly;
    logic [D_UN-1:0]           r_un_dly;

    always_ff @(posedge i_clk) begin
        r_y_dly[0]  <= r_y1;
        r_an_dly[0] <= r_anumn6;
        r_d2_dly[0] <= r_d2_8;
        r_r_dly[0]  <= w_r;
        for (int k = 1; k < D_Y; k++) r_y_dly[k] <= r_y_dly[k-1];
        for (int k = 1; k < D_AN; k++) r_an_dly[k] <= r_an_dly[k-1];
        for (int k = 1; k < D_D2; k++) r_d2_dly[k] <= r_d2_dly[k-1];
        for (int k = 1; k < D_R; k++) r_r_dly[k] <= r_r_dly[k-1];
        r_ng_dly <= {r_ng_dly[D_NG-2:0], r_ng6};
        r_un_dly <= {r_un_dly[D_UN-2:0], r_un5};
    end

    // CORDIC operands
    logic signed [CIN_W-1:0] r_en, r_ed, r_a1n, r_a1d, r_a2n, r_a2d;
    logic [45:0]             w_l2s;
    logic signed [COORD_W-1:0] w_yd;

    assign w_l2s = r_l2 * w_s;
    assign w_yd  = r_y_dly[D_Y-1];

    always_ff @(posedge i_clk) begin
        r_en  <= CIN_W'(w_s);
        r_ed  <= CIN_W'(r_an_dly[D_AN-1]);
        r_a1n <= {{(CIN_W-COORD_W-12){w_yd[COORD_W-1]}}, w_yd, 12'b0};
        r_a1d <= CIN_W'(r_r_dly[D_R-1]);
        r_a2n <= CIN_W'(w_l2s);
        r_a2d <= r_d2_dly[D_D2-1];
    end

    logic signed [ANG_W-1:0] w_ae, w_a1, w_a2;

    tlaja_cordic u_cordic_elbow (
        .i_clk (i_clk),
        .i_n   (r_en),
        .i_d   (r_ed),
        .o_ang (w_ae)
    );

    tlaja_cordic u_cordic_a1 (
        .i_clk (i_clk),
        .i_n   (r_a1n),
        .i_d   (r_a1d),
        .o_ang (w_a1)
    );

    tlaja_cordic u_cordic_a2 (
        .i_clk (i_clk),
        .i_n   (r_a2n),
        .i_d   (r_a2d),
        .o_ang (w_a2)
    );

    // combine angles
    logic signed [19:0] r_el1, r_sh1, r_sh2, w_ae20;
    logic [17:0]        r_elc2;
    logic               r_un1, r_un2;
    logic signed [21:0] w_wr8;
    logic signed [20:0] w_sh8;
    logic [18:0]        w_el8;
    logic signed [ANGLE_W-1:0] r_o_sh, r_o_wr;
    logic [ELBOW_W-1:0]        r_o_el;
    logic                      r_o_un;

    assign w_ae20 = {w_ae[ANG_W-1], w_ae};

    always_ff @(posedge i_clk) begin
        r_el1 <= r_ng_dly[D_NG-1] ? $signed(20'(PI16)) - w_ae20 : w_ae20;
        r_sh1 <= $signed(20'(HALF_PI16)) - {w_a1[ANG_W-1], w_a1}
                 - {w_a2[ANG_W-1], w_a2};
        r_un1 <= r_un_dly[D_UN-1];
        // clamp the elbow to [0, pi]
        if (r_el1[19]) begin
            r_elc2 <= '0;
        end else if (r_el1 > $signed(20'(PI16))) begin
            r_elc2 <= 18'(PI16);
        end else begin
            r_elc2 <= r_el1[17:0];
        end
        r_sh2 <= r_sh1;
        r_un2 <= r_un1;
    end

    assign w_wr8 = $signed(22'(PI16)) - $signed({4'b0, r_elc2})
                   - {{2{r_sh2[19]}}, r_sh2} + 22'sd8;
    assign w_sh8 = {r_sh2[19], r_sh2} + 21'sd8;
    assign w_el8 = {1'b0, r_elc2} + 19'd8;

    always_ff @(posedge i_clk) begin
        r_o_un <= r_un2;
        if (r_un2) begin
            r_o_sh <= '0;
            r_o_el <= '0;
            r_o_wr <= '0;
        end else begin
            r_o_sh <= w_sh8[19:4];
            r_o_el <= w_el8[17:4];
            r_o_wr <= w_wr8[19:4];
        end
    end

    assign o_valid          = r_vld[T_OUT-1];
    assign o_shoulder_angle = r_o_sh;
    assign o_elbow_angle    = r_o_el;
    assign o_wrist_angle    = r_o_wr;
    assign o_unreachable    = r_o_un;

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_unreachable |->
            o_shoulder_angle == '0 && o_elbow_angle == '0 && o_wrist_angle == '0)
        else $error("unreachable result with nonzero angles");

    a_elbow_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_elbow_angle <= ELBOW_W'(ELBOW_OUT_MAX))
        else $error("elbow angle above pi");

    a_start_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##T_OUT o_valid)
        else $error("transaction dropped in pipeline");

    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, T_OUT))
        else $error("result strobe without a transaction");

endmodule

FILE: dv/joint_angle_checker.sv
`timescale 1ns / 1ps

module joint_angle_checker
    import tlaja_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      busy,
    input  logic signed [COORD_W-1:0] i_target_x,
    input  logic signed [COORD_W-1:0] i_target_y,
    input  logic signed [COORD_W-1:0] i_target_z,
    input  logic                      o_valid,
    input  logic signed [ANGLE_W-1:0] o_shoulder_angle,
    input  logic [ELBOW_W-1:0]        o_elbow_angle,
    input  logic signed [ANGLE_W-1:0] o_wrist_angle,
    input  logic                      o_unreachable,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    input  logic                      pready,
    output int                        o_errors,
    output int                        o_pending
);

    typedef struct packed {
        logic signed [ANGLE_W-1:0] shoulder;
        logic [ELBOW_W-1:0]        elbow;
        logic signed [ANGLE_W-1:0] wrist;
        logic                      unreach;
    } t_angles;

    localparam longint HALF_PI = 64'sd102944;
    localparam longint FULL_PI = 64'sd205887;

    logic [LEN_W-1:0] upper_len;
    logic [LEN_W-1:0] fore_len;
    t_angles          angles_due[$];

    assign o_pending = angles_due.size();

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // vector angle of (xv, yv), xv > 0, in 2^-16 rad
    function automatic longint vector_angle(longint yv, longint xv);
        longint z;
        longint m;
        longint xn;
        longint yn;
        z = 0;
        m = (yv < 0) ? -yv : yv;
        if (xv > m)
            m = xv;
        while (m < (64'sd1 <<< NORM_BIT)) begin
            m = m * 2;
            xv = xv * 2;
            yv = yv * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (yv >= 0) begin
                xn = xv + (yv >>> i);
                yn = yv - (xv >>> i);
                z = z + longint'(ATAN_TAB[i]);
            end else begin
                xn = xv - (yv >>> i);
                yn = yv + (xv >>> i);
                z = z - longint'(ATAN_TAB[i]);
            end
            xv = xn;
            yv = yn;
        end
        return z;
    endfunction

    function automatic longint folded_atan(longint n, longint d);
        if (d == 0)
            return (n < 0) ? -HALF_PI : HALF_PI;
        if (d < 0) begin
            n = -n;
            d = -d;
        end
        return vector_angle(n, d);
    endfunction

    function automatic t_angles solve_joint_angles(longint x, longint y, longint z,
                                                   longint l1, longint l2);
        t_angles res;
        longint  num;
        longint  den;
        longint  anum;
        longint  s;
        longint  r;
        longint  elbow;
        longint  shoulder;
        longint  wrist;
        longint  rs;
        longint  re;
        longint  rw;
        res = '0;
        num = x * x + y * y + z * z - l1 * l1 - l2 * l2;
        den = 2 * l1 * l2;
        anum = (num < 0) ? -num : num;
        if (den == 0 || anum > den) begin
            res.unreach = 1'b1;
            return res;
        end
        while (den < (64'sd1 <<< 30)) begin
            den = den * 2;
            num = num * 2;
        end
        s = longint'(int_sqrt(64'(den * den) - 64'(num * num)));
        if (num < 0)
            elbow = FULL_PI - vector_angle(s, -num);
        else
            elbow = folded_atan(s, num);
        if (elbow < 0)
            elbow = 0;
        if (elbow > FULL_PI)
            elbow = FULL_PI;
        r = longint'(int_sqrt(64'(x * x + z * z) << 24));
        shoulder = HALF_PI - folded_atan(y * 4096, r) - folded_atan(l2 * s, l1 * den + l2 * num);
        wrist = FULL_PI - (elbow + shoulder);
        rs = (shoulder + 8) >>> 4;
        re = (elbow + 8) >>> 4;
        rw = (wrist + 8) >>> 4;
        res.shoulder = rs[ANGLE_W-1:0];
        res.elbow = re[ELBOW_W-1:0];
        res.wrist = rw[ANGLE_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("%0t checker: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_angles want;
        if (!i_rst_n) begin
            upper_len <= LEN_RESET;
            fore_len <= LEN_RESET;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (t_reg_idx'(paddr[2]) == REG_FIRST_LINK)
                    upper_len <= pwdata[LEN_W-1:0];
                else
                    fore_len <= pwdata[LEN_W-1:0];
            end
            if (start && !busy)
                angles_due.push_back(solve_joint_angles(i_target_x, i_target_y, i_target_z,
                                                        upper_len, fore_len));
            if (o_valid) begin
                if (angles_due.size() == 0) begin
                    flag_mismatch("unexpected result", 1, 0);
                end else begin
                    want = angles_due.pop_front();
                    if (o_shoulder_angle !== want.shoulder)
                        flag_mismatch("shoulder", o_shoulder_angle, want.shoulder);
                    if (o_elbow_angle !== want.elbow)
                        flag_mismatch("elbow", o_elbow_angle, want.elbow);
                    if (o_wrist_angle !== want.wrist)
                        flag_mismatch("wrist", o_wrist_angle, want.wrist);
                    if (o_unreachable !== want.unreach)
                        flag_mismatch("unreachable", o_unreachable, want.unreach);
                end
            end
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import tlaja_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic signed [COORD_W-1:0] i_target_x = '0;
    logic signed [COORD_W-1:0] i_target_y = '0;
    logic signed [COORD_W-1:0] i_target_z = '0;
    logic                      o_valid;
    logic signed [ANGLE_W-1:0] o_shoulder_angle;
    logic [ELBOW_W-1:0]        o_elbow_angle;
    logic signed [ANGLE_W-1:0] o_wrist_angle;
    logic                      o_unreachable;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [2:0]                paddr = '0;
    logic [31:0]               pwdata = '0;
    logic [31:0]               prdata;
    logic                      pready;
    int                        errors;
    int                        pending;
    int                        quiet_cycles = 0;
    int                        idle_pct = 15;
    int                        reach = 12712;

    always #5 i_clk = ~i_clk;

    two_link_arm_joint_angles dut (.*);

    joint_angle_checker checker_i (
        .o_errors (errors),
        .o_pending(pending),
        .*
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_target(int x, int y, int z);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_target_x <= x[COORD_W-1:0];
        i_target_y <= y[COORD_W-1:0];
        i_target_z <= z[COORD_W-1:0];
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_link(t_reg_idx idx, int value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic int coord_in_reach();
        int span;
        span = (reach > 32767) ? 32767 : reach;
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic random_targets(int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 70)
                send_target(coord_in_reach(), coord_in_reach(), coord_in_reach());
            else
                send_target($signed(16'($urandom)), $signed(16'($urandom)),
                            $signed(16'($urandom)));
        end
    endtask

    initial begin
        int l1;
        int l2;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // origin folds both atans onto a zero denominator
        send_target(0, 0, 0);
        send_target(12712, 0, 0);
        send_target(0, 12712, 0);
        send_target(0, -12712, 0);
        send_target(0, 0, -12712);
        send_target(0, 100, 0);
        send_target(0, -100, 0);
        send_target(32767, 32767, 32767);
        send_target(-32768, -32768, -32768);
        send_target(-32768, 0, 0);
        send_target(1, 0, 0);
        send_target(-1, -1, -1);
        send_target(-5000, 3000, -4000);
        send_target(8988, 8988, 0);
        send_target(0, 0, 6000);
        random_targets(100);
        // hold off until the pipeline is empty, then resume
        drain();
        random_targets(100);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin l1 = 32767; l2 = 32767; end
                1: begin l1 = 0;     l2 = 5000;  end
                2: begin l1 = 4000;  l2 = 0;     end
                3: begin l1 = 1;     l2 = 1;     end
                4: begin l1 = 32767; l2 = 1;     end
                default: begin
                    l1 = $urandom_range(32767);
                    l2 = $urandom_range(32767);
                end
            endcase
            idle_pct = (ph % 3 == 0) ? 81 : (ph % 3 == 1) ? 0 : 15;
            drain();
            write_link(REG_FIRST_LINK, l1);
            write_link(REG_SECOND_LINK, l2);
            reach = (l1 + l2 < 64) ? 64 : l1 + l2;
            send_target(0, 0, 0);
            send_target(l1 + l2, 0, 0);
            random_targets(170);
        end

        drain();
        repeat (80) @(posedge i_clk);
        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
src/tlaja_pkg.sv
src/tlaja_isqrt.sv
src/tlaja_cordic.sv
src/two_link_arm_joint_angles.sv
dv/joint_angle_checker.sv
dv/tb.sv
